@@ src/assert_macros.svh @@
// Assertion macros shared by the modular arithmetic unit RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a signal is stable while a condition holds.
`define ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

@@ src/mau_pkg.sv @@
// Package for the modular arithmetic unit: opcodes, state and command types.
// No dependencies.
`timescale 1ns / 1ps

package mau_pkg;

    localparam int DATA_WIDTH_DEF = 31;
    localparam logic [61:0] MODULUS_RESET = 62'd1000000007;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_REM = 3'd4,
        OP_NEG = 3'd5,
        OP_RSV6 = 3'd6,
        OP_RSV7 = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_A,
        ST_RED_B,
        ST_DISPATCH,
        ST_EUCLID,
        ST_MUL,
        ST_REM,
        ST_OUT
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;        // capture the input transaction
        logic red_a_start; // start reducing a mod m
        logic red_b_start; // start reducing |b| mod m
        logic simple;      // compute add, sub, neg or reserved result
        logic euc_start;   // start extended Euclid on (b, m)
        logic mul_start;   // start a*y mod m
        logic rem_start;   // start a mod b
        logic div_step;    // advance the shared divider by one bit
        logic euc_step;    // advance Euclid bookkeeping when a quotient is done
        logic mul_step;    // advance the multiplier by one bit
        logic fin_rem;     // take remainder as result
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic small_mod;   // modulus below two
        logic div_done;    // divider is in its last quotient-bit step
        logic euc_done;    // Euclid remainder reached zero
        logic euc_ok;      // gcd is one
        logic mul_done;    // multiplier is on its last bit
        logic b_zero;      // reduced b is zero
    } status_t;

endpackage

@@ src/mau_ctrl.sv @@
// Controller state machine for the modular arithmetic unit.
// Depends on mau_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mau_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  logic [2:0]        op,
    input  mau_pkg::status_t  sts,
    output mau_pkg::cmd_t     cmd
);

    mau_pkg::state_t state_reg, state_next;
    logic [2:0] op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mau_pkg::ST_IDLE;
            op_reg    <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            mau_pkg::ST_IDLE:
                if (in_valid)
                begin
                    state_next = mau_pkg::ST_RED_A;
                    op_next    = op;
                end
            mau_pkg::ST_RED_A:
                if (sts.small_mod)
                    state_next = mau_pkg::ST_OUT;
                else if (sts.div_done)
                    state_next = mau_pkg::ST_RED_B;
            mau_pkg::ST_RED_B:
                if (sts.div_done)
                    state_next = mau_pkg::ST_DISPATCH;
            mau_pkg::ST_DISPATCH:
                case (op_reg)
                    mau_pkg::OP_MUL: state_next = mau_pkg::ST_MUL;
                    mau_pkg::OP_DIV: state_next = mau_pkg::ST_EUCLID;
                    mau_pkg::OP_REM:
                        state_next = sts.b_zero ? mau_pkg::ST_OUT : mau_pkg::ST_REM;
                    default: state_next = mau_pkg::ST_OUT;
                endcase
            mau_pkg::ST_EUCLID:
                if (sts.euc_done)
                    state_next = sts.euc_ok ? mau_pkg::ST_MUL : mau_pkg::ST_OUT;
            mau_pkg::ST_MUL:
                if (sts.mul_done)
                    state_next = mau_pkg::ST_OUT;
            mau_pkg::ST_REM:
                if (sts.div_done)
                    state_next = mau_pkg::ST_OUT;
            mau_pkg::ST_OUT:
                if (!out_stall)
                    state_next = mau_pkg::ST_IDLE;
            default: state_next = mau_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = (state_reg != mau_pkg::ST_IDLE);
        out_valid = (state_reg == mau_pkg::ST_OUT);
        unique case (state_reg)
            mau_pkg::ST_IDLE:
            begin
                cmd.load        = in_valid;
                cmd.red_a_start = in_valid;
            end
            mau_pkg::ST_RED_A:
            begin
                cmd.div_step    = 1'b1;
                cmd.red_b_start = sts.div_done;
            end
            mau_pkg::ST_RED_B:
                cmd.div_step = 1'b1;
            mau_pkg::ST_DISPATCH:
            begin
                cmd.simple    = 1'b1;
                cmd.mul_start = (op_reg == mau_pkg::OP_MUL);
                cmd.euc_start = (op_reg == mau_pkg::OP_DIV);
                cmd.rem_start = (op_reg == mau_pkg::OP_REM);
            end
            mau_pkg::ST_EUCLID:
            begin
                cmd.div_step  = 1'b1;
                cmd.euc_step  = sts.div_done;
                cmd.mul_start = sts.euc_done && sts.euc_ok;
            end
            mau_pkg::ST_MUL:
                cmd.mul_step = 1'b1;
            mau_pkg::ST_REM:
            begin
                cmd.div_step = 1'b1;
                cmd.fin_rem  = sts.div_done;
            end
            mau_pkg::ST_OUT: ;
            default: ;
        endcase
    end

    `ASSERT_IMPL(a_accept_only_idle, clk, rst_n,
        (in_valid && !in_stall) |=> (state_reg == mau_pkg::ST_RED_A), "accept left idle wrongly")
    `ASSERT_IMPL(a_out_then_idle, clk, rst_n,
        (out_valid && !out_stall) |=> (state_reg == mau_pkg::ST_IDLE), "result not retired")

endmodule

@@ src/mau_datapath.sv @@
// Datapath for the modular arithmetic unit: a shared restoring divider,
// extended Euclid bookkeeping and a shift-add modular multiplier. Uses mau_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mau_datapath
#(
    parameter int DATA_WIDTH = mau_pkg::DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [DATA_WIDTH-1:0] modulus,
    input  logic [2:0]            req_type,
    input  logic [DATA_WIDTH-1:0] operand_a,
    input  logic [31:0]           operand_b,
    input  mau_pkg::cmd_t         cmd,
    output mau_pkg::status_t      sts,
    output logic [DATA_WIDTH-1:0] result,
    output logic                  op_error
);

    // Divider handles dividends up to the wider of DATA_WIDTH and 32 bits.
    localparam int NW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam int CW = $clog2(NW + 1);
    localparam int SW = DATA_WIDTH + 2;   // signed Bezout coefficient width
    localparam int MW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] m_reg, a_reg, a_next, b_reg, b_next;
    logic [2:0]            op_reg;
    logic                  bneg_reg;
    logic [31:0]           bmag_reg;
    logic [DATA_WIDTH-1:0] b_red;

    // Shared divider: quotient register shifts the dividend out bit by bit.
    logic [NW-1:0]         q_reg, q_next;
    logic [DATA_WIDTH:0]   rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   div_rem_fin;
    logic [NW-1:0]         div_quo_fin;

    // Euclid state.
    logic [DATA_WIDTH-1:0] r1_reg, r1_next;
    logic signed [SW-1:0]  x0_reg, x0_next, x1_reg, x1_next;
    logic signed [SW-1:0]  qx_prod;

    // Multiplier state.
    logic [DATA_WIDTH-1:0] acc_reg, acc_next, mx_reg, mx_next, my_reg, my_next;
    logic [MW-1:0]         mcnt_reg, mcnt_next;
    logic [DATA_WIDTH:0]   sum_acc, sum_dbl;

    logic [DATA_WIDTH-1:0] res_reg, res_next;
    logic                  err_reg, err_next;
    logic [DATA_WIDTH-1:0] inv;
    logic [DATA_WIDTH:0]   add_s, sub_s;

    // During the last divide step the final quotient and remainder are not yet
    // registered, so they are formed here for whoever consumes them at div_done.
    always_comb
    begin
        shifted     = {rem_reg[DATA_WIDTH-1:0], q_reg[NW-1]};
        trial       = shifted - {1'b0, dvs_reg};
        div_rem_fin = trial[DATA_WIDTH] ? shifted : trial;
        div_quo_fin = {q_reg[NW-2:0], ~trial[DATA_WIDTH]};
    end

    assign b_red   = (bneg_reg && rem_reg != '0)
                   ? DATA_WIDTH'({1'b0, m_reg} - rem_reg) : rem_reg[DATA_WIDTH-1:0];
    assign qx_prod = $signed({1'b0, div_quo_fin[DATA_WIDTH-1:0]}) * x1_reg;
    assign sum_acc = {1'b0, acc_reg} + {1'b0, mx_reg};
    assign sum_dbl = {1'b0, mx_reg} + {1'b0, mx_reg};
    assign add_s   = {1'b0, a_reg} + {1'b0, b_reg};
    assign sub_s   = {1'b0, a_reg} - {1'b0, b_reg};
    // The final Euclid step moves x1 into x0, so the inverse is read from x1.
    assign inv     = (x1_reg < 0) ? DATA_WIDTH'(x1_reg + SW'(m_reg))
                                  : DATA_WIDTH'(x1_reg);

    always_comb
    begin
        a_next = a_reg; b_next = b_reg;
        q_next = q_reg; rem_next = rem_reg; dvs_next = dvs_reg;
        cnt_next = cnt_reg; busy_next = busy_reg;
        r1_next = r1_reg; x0_next = x0_reg; x1_next = x1_reg;
        acc_next = acc_reg; mx_next = mx_reg; my_next = my_reg; mcnt_next = mcnt_reg;
        res_next = res_reg; err_next = err_reg;

        if (cmd.div_step && busy_reg)
        begin
            q_next = {q_reg[NW-2:0], 1'b0};
            if (!trial[DATA_WIDTH])
            begin
                rem_next  = trial;
                q_next[0] = 1'b1;
            end
            else
                rem_next = shifted;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end

        if (cmd.load)
        begin
            res_next = '0;
            err_next = 1'b0;
        end
        if (cmd.red_a_start)
        begin
            q_next    = NW'(operand_a);
            rem_next  = '0;
            dvs_next  = modulus;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        if (cmd.red_b_start)
        begin
            a_next    = div_rem_fin[DATA_WIDTH-1:0];
            q_next    = NW'(bmag_reg);
            rem_next  = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        if (cmd.simple)
        begin
            b_next = b_red;
            unique case (op_reg)
                mau_pkg::OP_ADD:
                    res_next = (add_s >= {1'b0, m_reg}) ? DATA_WIDTH'(add_s - {1'b0, m_reg})
                                                         : add_s[DATA_WIDTH-1:0];
                mau_pkg::OP_SUB:
                    res_next = sub_s[DATA_WIDTH] ? DATA_WIDTH'(sub_s + {1'b0, m_reg})
                                                 : sub_s[DATA_WIDTH-1:0];
                mau_pkg::OP_NEG:
                    res_next = (a_reg == '0) ? '0 : m_reg - a_reg;
                default: res_next = '0;
            endcase
            // b_reg above is still the old value, so add/sub use the fresh one here.
            unique case (op_reg)
                mau_pkg::OP_ADD, mau_pkg::OP_SUB:
                begin
                    if (op_reg == mau_pkg::OP_ADD)
                    begin
                        if ({1'b0, a_reg} + {1'b0, b_next} >= {1'b0, m_reg})
                            res_next = DATA_WIDTH'({1'b0, a_reg} + {1'b0, b_next}
                                                   - {1'b0, m_reg});
                        else
                            res_next = DATA_WIDTH'({1'b0, a_reg} + {1'b0, b_next});
                    end
                    else if (a_reg >= b_next)
                        res_next = a_reg - b_next;
                    else
                        res_next = DATA_WIDTH'({1'b0, a_reg} + {1'b0, m_reg}
                                               - {1'b0, b_next});
                end
                default: ;
            endcase
            err_next = (op_reg == mau_pkg::OP_REM) && (b_next == '0);
        end
        if (cmd.euc_start)
        begin
            // Inverse of b via Euclid on (b, m); first step divides b by m.
            r1_next   = m_reg;
            x0_next   = SW'(1); x1_next = '0;
            q_next    = NW'(b_next);
            rem_next  = '0;
            dvs_next  = m_reg;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        if (cmd.euc_step)
        begin
            r1_next = div_rem_fin[DATA_WIDTH-1:0];
            x0_next = x1_reg;
            x1_next = x0_reg - qx_prod;
            if (div_rem_fin != '0)
            begin
                q_next    = NW'(r1_reg);
                rem_next  = '0;
                dvs_next  = div_rem_fin[DATA_WIDTH-1:0];
                cnt_next  = CW'(NW);
                busy_next = 1'b1;
            end
        end
        if (cmd.simple && op_reg == mau_pkg::OP_MUL)
        begin
            acc_next = '0; mx_next = a_reg; my_next = b_next; mcnt_next = MW'(DATA_WIDTH);
        end
        else if (cmd.mul_start)
        begin
            acc_next = '0; mx_next = a_reg; my_next = inv; mcnt_next = MW'(DATA_WIDTH);
        end
        if (cmd.mul_step && mcnt_reg != '0)
        begin
            if (my_reg[0])
                acc_next = (sum_acc >= {1'b0, m_reg}) ? DATA_WIDTH'(sum_acc - {1'b0, m_reg})
                                                      : sum_acc[DATA_WIDTH-1:0];
            mx_next   = (sum_dbl >= {1'b0, m_reg}) ? DATA_WIDTH'(sum_dbl - {1'b0, m_reg})
                                                   : sum_dbl[DATA_WIDTH-1:0];
            my_next   = my_reg >> 1;
            mcnt_next = mcnt_reg - 1'b1;
            if (mcnt_reg == MW'(1))
                res_next = (my_reg[0]) ? acc_next : acc_reg;
        end
        if (cmd.rem_start)
        begin
            q_next    = NW'(a_reg);
            rem_next  = '0;
            dvs_next  = b_next;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        if (cmd.fin_rem)
            res_next = div_rem_fin[DATA_WIDTH-1:0];
        if (cmd.euc_step && div_rem_fin == '0 && r1_reg != DATA_WIDTH'(1))
        begin
            err_next = 1'b1;
            res_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            mcnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            mcnt_reg <= mcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_reg    <= modulus;
            op_reg   <= req_type;
            bneg_reg <= operand_b[31];
            bmag_reg <= operand_b[31] ? (~operand_b + 32'd1) : operand_b;
        end
        a_reg <= a_next;   b_reg <= b_next;
        q_reg <= q_next;   rem_reg <= rem_next; dvs_reg <= dvs_next;
        r1_reg <= r1_next; x0_reg <= x0_next; x1_reg <= x1_next;
        acc_reg <= acc_next; mx_reg <= mx_next; my_reg <= my_next;
        res_reg <= res_next; err_reg <= err_next;
    end

    // Euclid stops when the new remainder is zero; gcd is then r1.
    always_comb
    begin
        sts.small_mod = (m_reg < DATA_WIDTH'(2));
        sts.div_done  = busy_reg && (cnt_reg == CW'(1));
        sts.euc_done  = sts.div_done && (div_rem_fin == '0);
        sts.euc_ok    = (r1_reg == DATA_WIDTH'(1));
        sts.mul_done  = (mcnt_reg == MW'(1));
        sts.b_zero    = (b_red == '0);
    end

    assign result   = res_reg;
    assign op_error = err_reg;

    `ASSERT_IMPL(a_res_below_m, clk, rst_n,
        (cmd.fin_rem) |=> (res_reg < m_reg), "remainder not below modulus")

endmodule

@@ src/modular_arithmetic_unit_top.sv @@
// Top level of the modular arithmetic unit: modulus register, controller
// and datapath. Depends on mau_pkg, mau_ctrl and mau_datapath.
// Usage:
//   Input channel in_valid/in_stall carries req_type, operand_a, operand_b.
//   Output channel out_valid/out_stall carries result and op_error.
//   The modulus register is written over cfg_valid/cfg_ready/cfg_data;
//   the user must write it only while the unit is idle, as the block
//   does not enforce this; cfg_ready is always high. One transaction is
//   processed at a time. A bit-serial restoring divider reduces a, then
//   |b|; add/sub/negate then finish in the dispatch state and out_valid
//   rises in the output state. Multiply then runs a shift-add multiplier
//   over DATA_WIDTH bits, and remainder one more divide pass. Divide runs
//   extended Euclid, each quotient step a full divide pass, then a multiply.
//   With a modulus below two the controller goes straight from reducing a
//   to output. The next input can be accepted in the cycle after the result.
//   Reset returns to idle and loads the modulus with 1000000007.
//   While out_stall is high the result holds and no new input is taken.
`timescale 1ns / 1ps
module modular_arithmetic_unit_top
#(
    parameter int DATA_WIDTH = mau_pkg::DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            req_type,
    input  logic [DATA_WIDTH-1:0] operand_a,
    input  logic signed [31:0]    operand_b,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DATA_WIDTH-1:0] result,
    output logic                  op_error,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [DATA_WIDTH-1:0] cfg_data
);

    logic [DATA_WIDTH-1:0] modulus_reg;
    mau_pkg::cmd_t         cmd;
    mau_pkg::status_t      sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= DATA_WIDTH'(mau_pkg::MODULUS_RESET);
        else if (cfg_valid && cfg_ready)
            modulus_reg <= cfg_data;
    end

    mau_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .op        (req_type),
        .sts       (sts),
        .cmd       (cmd)
    );

    mau_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .modulus   (modulus_reg),
        .req_type  (req_type),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result),
        .op_error  (op_error)
    );

endmodule
